@@ rtl/cau_pkg.sv @@
// cau_pkg: shared types, codes and helpers for the complex arithmetic unit.
// No dependencies.
`default_nettype none

package cau_pkg;

   localparam int FRAC_BITS = 16;

   localparam int WORD_W    = 32;
   localparam int PROD_W    = 2 * WORD_W;
   localparam int MUL_STEPS = WORD_W;
   localparam int DIV_STEPS = PROD_W + FRAC_BITS;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);

   localparam logic [WORD_W-1:0] ONE_FIX  = WORD_W'(1) << FRAC_BITS;
   localparam logic [WORD_W-1:0] POS_MAX  = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0] NEG_MIN  = {1'b1, {(WORD_W-1){1'b0}}};

   // operation kinds
   localparam logic [2:0] K_ADD = 3'd0;
   localparam logic [2:0] K_SUB = 3'd1;
   localparam logic [2:0] K_MUL = 3'd2;
   localparam logic [2:0] K_DIV = 3'd3;
   localparam logic [2:0] K_POW = 3'd4;
   localparam logic [2:0] K_EQ  = 3'd5;

   // result status
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OVF  = 2'd1;
   localparam logic [1:0] ST_DIVZ = 2'd2;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b00_0000_0001,
      S_EXEC  = 10'b00_0000_0010,
      S_LOAD  = 10'b00_0000_0100,
      S_MUL   = 10'b00_0000_1000,
      S_ACC   = 10'b00_0001_0000,
      S_NORM  = 10'b00_0010_0000,
      S_DINIT = 10'b00_0100_0000,
      S_DIV   = 10'b00_1000_0000,
      S_DFIN  = 10'b01_0000_0000,
      S_OUT   = 10'b10_0000_0000
   } state_type;

   // Sign-magnitude to saturated word; bit WORD_W is the overflow flag.
   function automatic logic [WORD_W:0] sat_word(input logic neg,
                                                input logic [PROD_W-1:0] mag);
      logic [WORD_W:0] r;
      if (!neg) begin
         if (mag > PROD_W'(POS_MAX)) r = {1'b1, POS_MAX};
         else                        r = {1'b0, mag[WORD_W-1:0]};
      end else begin
         if (mag > PROD_W'(NEG_MIN)) r = {1'b1, NEG_MIN};
         else                        r = {1'b0, WORD_W'(0) - mag[WORD_W-1:0]};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/complex_arithmetic_unit.sv @@
// complex_arithmetic_unit: top level of the complex fixed-point ALU.
// Depends on cau_pkg; one bit-serial multiplier and one bit-serial divider.
//
// Usage
//   Request channel req_*: one transaction carries the operation kind in
//   req_tuser and both Q16.16 complex operands plus the exponent in req_tdata.
//   Response channel rsp_*: one transaction per request with the result in
//   rsp_tdata and the status (ok, overflow, divide by zero) in rsp_tuser.
// Sequencing
//   Add, subtract, equality: after acceptance the request passes S_EXEC and
//   S_OUT, which registers rsp_tvalid unless an earlier response is stalled.
//   Each product runs through the shift-add multiplier one bit per cycle,
//   with load and accumulate states around it. Multiply uses 4 products.
//   Power uses 4 products per exponent step. Divide uses 6 products plus
//   two restoring divisions.
//   One request is worked on at a time; the next is taken once the previous
//   result has moved into the response register.
// Reset: synchronous, clears the sequencer and the response valid.
// Stall: a result waiting on rsp_tready holds the response register; the
//   core may already accept and compute the next request.
`default_nettype none

module complex_arithmetic_unit
   import cau_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // a_re[31:0], a_im[63:32], b_re[95:64], b_im[127:96], power_exp[131:128]
   input  wire logic [135:0] req_tdata,
   // kind[2:0]
   input  wire logic [2:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // res_re[31:0], res_im[63:32], is_equal[64]
   output logic [71:0]       rsp_tdata,
   // status[1:0]
   output logic [1:0]        rsp_tuser
);

   state_type state_ff, state_in;

   logic [2:0]        kind_ff, kind_in;
   logic [WORD_W-1:0] ar_ff, ar_in, ai_ff, ai_in, br_ff, br_in, bi_ff, bi_in;
   logic [3:0]        pw_ff, pw_in;
   logic [WORD_W-1:0] cur_re_ff, cur_re_in, cur_im_ff, cur_im_in;
   logic [PROD_W:0]   acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic [PROD_W-1:0] den_ff, den_in;
   logic [2:0]        step_ff, step_in;
   logic [WORD_W-1:0] mcand_ff, mcand_in;
   logic [PROD_W-1:0] p_ff, p_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              ovf_ff, ovf_in, divz_ff, divz_in, eq_ff, eq_in;
   logic              part_ff, part_in;
   logic [PROD_W-1:0] dvd_ff, dvd_in, rem_ff, rem_in;
   logic [WORD_W-1:0] quo_ff, quo_in;
   logic              big_ff, big_in;

   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [71:0]       rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]        rsp_tuser_ff, rsp_tuser_in;

   // combinational helpers
   logic [WORD_W-1:0] ur, ui, vr, vi, opx, opy;
   logic              negflag;
   logic [WORD_W:0]   sum33, diff33, mac33, sat_re, sat_im, sat_q;
   logic [PROD_W:0]   ext, sval, src, nre_abs, nim_abs, r2;
   logic              is_pow, is_div;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   always_comb begin
      is_pow = (kind_ff == K_POW);
      is_div = (kind_ff == K_DIV);
      ur = is_pow ? cur_re_ff : ar_ff;
      ui = is_pow ? cur_im_ff : ai_ff;
      vr = is_pow ? ar_ff : br_ff;
      vi = is_pow ? ai_ff : bi_ff;
      case (step_ff)
         3'd0:    begin opx = ur; opy = vr; end
         3'd1:    begin opx = ui; opy = vi; end
         3'd2:    begin opx = ur; opy = vi; end
         3'd3:    begin opx = ui; opy = vr; end
         3'd4:    begin opx = vr; opy = vr; end
         default: begin opx = vi; opy = vi; end
      endcase
      // re gets -ui*vi for multiply; im gets -ur*vi for divide
      negflag = ((step_ff == 3'd1) && !is_div) || ((step_ff == 3'd2) && is_div);

      sum33  = {ar_ff[WORD_W-1], ar_ff} + {br_ff[WORD_W-1], br_ff};
      diff33 = {ar_ff[WORD_W-1], ar_ff} - {br_ff[WORD_W-1], br_ff};
      mac33  = {1'b0, p_ff[PROD_W-1:WORD_W]} + (p_ff[0] ? {1'b0, mcand_ff} : 33'd0);

      ext  = {1'b0, p_ff};
      sval = neg_ff ? ((PROD_W+1)'(0) - ext) : ext;

      nre_abs = acc_re_ff[PROD_W] ? ((PROD_W+1)'(0) - acc_re_ff) : acc_re_ff;
      nim_abs = acc_im_ff[PROD_W] ? ((PROD_W+1)'(0) - acc_im_ff) : acc_im_ff;
      sat_re  = sat_word(acc_re_ff[PROD_W], nre_abs[PROD_W-1:0] >> FRAC_BITS);
      sat_im  = sat_word(acc_im_ff[PROD_W], nim_abs[PROD_W-1:0] >> FRAC_BITS);

      src = part_ff ? acc_im_ff : acc_re_ff;
      r2  = {rem_ff, dvd_ff[PROD_W-1]};
      sat_q = sat_word(neg_ff, big_ff ? (PROD_W'(1) << WORD_W) : PROD_W'(quo_ff));
   end

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff; ar_in = ar_ff; ai_in = ai_ff; br_in = br_ff; bi_in = bi_ff;
      pw_in = pw_ff; cur_re_in = cur_re_ff; cur_im_in = cur_im_ff;
      acc_re_in = acc_re_ff; acc_im_in = acc_im_ff; den_in = den_ff;
      step_in = step_ff; mcand_in = mcand_ff; p_in = p_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; ovf_in = ovf_ff; divz_in = divz_ff; eq_in = eq_ff;
      part_in = part_ff; dvd_in = dvd_ff; rem_in = rem_ff; quo_in = quo_ff;
      big_in = big_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in = rsp_tdata_ff; rsp_tuser_in = rsp_tuser_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in = req_tuser;
               ar_in = req_tdata[31:0];   ai_in = req_tdata[63:32];
               br_in = req_tdata[95:64];  bi_in = req_tdata[127:96];
               pw_in = req_tdata[131:128];
               ovf_in = 1'b0; divz_in = 1'b0; eq_in = 1'b0;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cur_re_in = '0; cur_im_in = '0;
            acc_re_in = '0; acc_im_in = '0; den_in = '0;
            step_in = '0; part_in = 1'b0;
            state_in = S_OUT;
            case (kind_ff)
               K_ADD, K_SUB: begin
                  logic [WORD_W:0] t;
                  logic [WORD_W:0] u;
                  t = (kind_ff == K_ADD) ? sum33 : diff33;
                  u = {ai_ff[WORD_W-1], ai_ff} +
                      ((kind_ff == K_ADD) ? {bi_ff[WORD_W-1], bi_ff}
                                          : ((WORD_W+1)'(0) - {bi_ff[WORD_W-1], bi_ff}));
                  cur_re_in = (t[WORD_W] != t[WORD_W-1]) ?
                              (t[WORD_W] ? NEG_MIN : POS_MAX) : t[WORD_W-1:0];
                  cur_im_in = (u[WORD_W] != u[WORD_W-1]) ?
                              (u[WORD_W] ? NEG_MIN : POS_MAX) : u[WORD_W-1:0];
                  ovf_in = (t[WORD_W] != t[WORD_W-1]) || (u[WORD_W] != u[WORD_W-1]);
               end
               K_MUL: state_in = S_LOAD;
               K_DIV: begin
                  if (br_ff == '0 && bi_ff == '0) divz_in = 1'b1;
                  else                            state_in = S_LOAD;
               end
               K_POW: begin
                  cur_re_in = ONE_FIX;
                  if (pw_ff != '0) state_in = S_LOAD;
               end
               K_EQ: eq_in = (ar_ff == br_ff) && (ai_ff == bi_ff);
               default: ;
            endcase
         end
         S_LOAD: begin
            mcand_in = opx[WORD_W-1] ? (WORD_W'(0) - opx) : opx;
            p_in     = {WORD_W'(0), opy[WORD_W-1] ? (WORD_W'(0) - opy) : opy};
            neg_in   = opx[WORD_W-1] ^ opy[WORD_W-1] ^ negflag;
            cnt_in   = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            p_in   = {mac33, p_ff[WORD_W-1:1]};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(MUL_STEPS - 1)) state_in = S_ACC;
         end
         S_ACC: begin
            if (step_ff < 3'd2)      acc_re_in = acc_re_ff + sval;
            else if (step_ff < 3'd4) acc_im_in = acc_im_ff + sval;
            else                     den_in    = den_ff + p_ff;
            step_in = step_ff + 3'd1;
            if (is_div) state_in = (step_ff == 3'd5) ? S_DINIT : S_LOAD;
            else        state_in = (step_ff == 3'd3) ? S_NORM  : S_LOAD;
         end
         S_NORM: begin
            cur_re_in = sat_re[WORD_W-1:0];
            cur_im_in = sat_im[WORD_W-1:0];
            ovf_in    = ovf_ff | sat_re[WORD_W] | sat_im[WORD_W];
            acc_re_in = '0; acc_im_in = '0; step_in = '0;
            pw_in     = pw_ff - 4'd1;
            state_in  = (is_pow && pw_ff != 4'd1) ? S_LOAD : S_OUT;
         end
         S_DINIT: begin
            logic [PROD_W:0] m;
            m = src[PROD_W] ? ((PROD_W+1)'(0) - src) : src;
            neg_in = src[PROD_W];
            dvd_in = m[PROD_W-1:0];
            rem_in = '0; quo_in = '0; big_in = 1'b0; cnt_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            logic qb;
            qb = (r2 >= {1'b0, den_ff});
            rem_in = qb ? PROD_W'(r2 - {1'b0, den_ff}) : r2[PROD_W-1:0];
            dvd_in = {dvd_ff[PROD_W-2:0], 1'b0};
            quo_in = {quo_ff[WORD_W-2:0], qb};
            big_in = big_ff | quo_ff[WORD_W-1];
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) state_in = S_DFIN;
         end
         S_DFIN: begin
            if (part_ff) cur_im_in = sat_q[WORD_W-1:0];
            else         cur_re_in = sat_q[WORD_W-1:0];
            ovf_in  = ovf_ff | sat_q[WORD_W];
            part_in = 1'b1;
            state_in = part_ff ? S_OUT : S_DINIT;
         end
         S_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {7'd0, eq_ff, cur_im_ff, cur_re_ff};
               rsp_tuser_in  = divz_ff ? ST_DIVZ : (ovf_ff ? ST_OVF : ST_OK);
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      kind_ff <= kind_in; ar_ff <= ar_in; ai_ff <= ai_in; br_ff <= br_in; bi_ff <= bi_in;
      pw_ff <= pw_in; cur_re_ff <= cur_re_in; cur_im_ff <= cur_im_in;
      acc_re_ff <= acc_re_in; acc_im_ff <= acc_im_in; den_ff <= den_in;
      step_ff <= step_in; mcand_ff <= mcand_in; p_ff <= p_in; neg_ff <= neg_in;
      cnt_ff <= cnt_in; ovf_ff <= ovf_in; divz_ff <= divz_in; eq_ff <= eq_in;
      part_ff <= part_in; dvd_ff <= dvd_in; rem_ff <= rem_in; quo_ff <= quo_in;
      big_ff <= big_in;
      rsp_tdata_ff <= rsp_tdata_in; rsp_tuser_ff <= rsp_tuser_in;
   end

endmodule

`default_nettype wire

@@ rtl/cau_checker.sv @@
// cau_checker: port-level assertions for complex_arithmetic_unit, bound below.
// Depends on cau_pkg.
`default_nettype none

module cau_checker
   import cau_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic [135:0] req_tdata,
   input wire logic [2:0]   req_tuser,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [71:0]  rsp_tdata,
   input wire logic [1:0]   rsp_tuser
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == ST_OK || rsp_tuser == ST_OVF || rsp_tuser == ST_DIVZ))
      else $error("bad status code");

   a_divz: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_DIVZ |-> rsp_tdata[63:0] == 64'd0 && !rsp_tdata[64])
      else $error("divide by zero with nonzero result");

   a_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[64] |-> rsp_tuser == ST_OK && rsp_tdata[63:0] == 64'd0)
      else $error("equality flag with data or status");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);

`default_nettype wire
